FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the unescaper RTL.
// No dependencies; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: property violated");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: hw/rtl/csu_pkg.sv
// Shared types and constants for the C string unescaper.
// No dependencies.
package csu_pkg;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_BODY = 2'd1,
      PH_ESC  = 2'd2,
      PH_OCT  = 2'd3
   } phase_type;

   // escape tracking state carried from one character to the next
   typedef struct packed {
      phase_type  phase;
      logic [7:0] octal_value;
      logic [1:0] octal_digits;
   } esc_state_type;

   localparam logic [2:0] KIND_DATA    = 3'd0;
   localparam logic [2:0] KIND_OK      = 3'd1;
   localparam logic [2:0] KIND_BADESC  = 3'd2;
   localparam logic [2:0] KIND_NOQUOTE = 3'd3;
   localparam logic [2:0] KIND_EARLY   = 3'd4;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_SEVEN  = 8'h37;

   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_TAB = 8'h09;

   localparam esc_state_type ESC_STATE_IDLE = '{phase: PH_IDLE, octal_value: 8'h00,
                                                octal_digits: 2'd0};

endpackage

FILE: hw/rtl/csu_step.sv
// Combinational next-state and result logic for one input character.
// Depends on csu_pkg.
module csu_step
   import csu_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   quote_mode,
   input  logic [7:0]             char_in,
   input  esc_state_type          cur_state,
   input  logic [COUNT_WIDTH-1:0] cur_byte_count,
   input  logic [COUNT_WIDTH-1:0] cur_char_count,
   output esc_state_type          nxt_state,
   output logic [COUNT_WIDTH-1:0] nxt_byte_count,
   output logic [COUNT_WIDTH-1:0] nxt_char_count,
   output logic [1:0]             n_results,
   output logic                   done,
   output logic [7:0]             res_byte [2],
   output logic [2:0]             res_kind [2],
   output logic [COUNT_WIDTH-1:0] res_length [2],
   output logic [COUNT_WIDTH-1:0] res_consumed [2]
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic is_digit;
   assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_SEVEN);

   always_comb begin
      esc_state_type          st;
      logic [COUNT_WIDTH-1:0] bc;
      logic [COUNT_WIDTH-1:0] cc;
      logic [1:0]             k;
      logic                   do_body;
      logic [1:0]             od;
      logic [7:0]             ov;

      st      = cur_state;
      bc      = cur_byte_count;
      cc      = cur_char_count;
      k       = 2'd0;
      do_body = 1'b0;
      done    = 1'b0;
      od      = 2'd0;
      ov      = 8'h00;
      for (int i = 0; i < 2; i++) begin
         res_byte[i]     = 8'h00;
         res_kind[i]     = KIND_DATA;
         res_length[i]   = '0;
         res_consumed[i] = '0;
      end

      unique case (cur_state.phase)
         PH_IDLE: begin
            if (quote_mode) begin
               if (char_in == CHAR_QUOTE) begin
                  cc       = (cc == COUNT_MAX) ? cc : cc + 1'b1;
                  st.phase = PH_BODY;
               end else begin
                  res_kind[0]     = (char_in == CHAR_NUL) ? KIND_EARLY : KIND_NOQUOTE;
                  res_length[0]   = bc;
                  res_consumed[0] = cc;
                  k    = 2'd1;
                  done = 1'b1;
               end
            end else begin
               do_body = 1'b1;
            end
         end
         PH_BODY: begin
            do_body = 1'b1;
         end
         PH_ESC: begin
            if (char_in == CHAR_R || char_in == CHAR_N || char_in == CHAR_T ||
                char_in == CHAR_BSLASH || char_in == CHAR_QUOTE) begin
               cc       = (cc == COUNT_MAX) ? cc : cc + 1'b1;
               bc       = (bc == COUNT_MAX) ? bc : bc + 1'b1;
               st.phase = PH_BODY;
               priority if (char_in == CHAR_R) res_byte[0] = BYTE_CR;
               else if (char_in == CHAR_N)     res_byte[0] = BYTE_LF;
               else if (char_in == CHAR_T)     res_byte[0] = BYTE_TAB;
               else                            res_byte[0] = char_in;
               res_length[0]   = bc;
               res_consumed[0] = cc;
               k = 2'd1;
            end else if (is_digit) begin
               cc              = (cc == COUNT_MAX) ? cc : cc + 1'b1;
               st.octal_value  = {5'b0, char_in[2:0]};
               st.octal_digits = 2'd1;
               st.phase        = PH_OCT;
            end else begin
               res_kind[0]     = KIND_BADESC;
               res_length[0]   = bc;
               res_consumed[0] = cc;
               k    = 2'd1;
               done = 1'b1;
            end
         end
         PH_OCT: begin
            if (is_digit) begin
               cc = (cc == COUNT_MAX) ? cc : cc + 1'b1;
               ov = {cur_state.octal_value[4:0], 3'b000} + {5'b0, char_in[2:0]};
               od = cur_state.octal_digits + 2'd1;
               st.octal_value  = ov;
               st.octal_digits = od;
               // third digit (or wrapped count) flushes the byte now
               if (od == 2'd3 || od == 2'd0) begin
                  bc              = (bc == COUNT_MAX) ? bc : bc + 1'b1;
                  res_byte[0]     = ov;
                  res_length[0]   = bc;
                  res_consumed[0] = cc;
                  k               = 2'd1;
                  st.octal_value  = 8'h00;
                  st.octal_digits = 2'd0;
                  st.phase        = PH_BODY;
               end
            end else begin
               // flush the pending byte, then treat this character as text
               bc              = (bc == COUNT_MAX) ? bc : bc + 1'b1;
               res_byte[0]     = cur_state.octal_value;
               res_length[0]   = bc;
               res_consumed[0] = cc;
               k               = 2'd1;
               st.octal_value  = 8'h00;
               st.octal_digits = 2'd0;
               do_body         = 1'b1;
            end
         end
         default: begin
            st = ESC_STATE_IDLE;
         end
      endcase

      if (do_body) begin
         st.phase = PH_BODY;
         if (char_in == CHAR_NUL || char_in == CHAR_QUOTE) begin
            if (char_in == CHAR_QUOTE && quote_mode) begin
               cc = (cc == COUNT_MAX) ? cc : cc + 1'b1;
            end
            res_kind[k[0]]     = (char_in == CHAR_NUL && quote_mode) ? KIND_EARLY : KIND_OK;
            res_length[k[0]]   = bc;
            res_consumed[k[0]] = cc;
            k    = k + 2'd1;
            done = 1'b1;
         end else begin
            cc = (cc == COUNT_MAX) ? cc : cc + 1'b1;
            if (char_in == CHAR_BSLASH) begin
               st.phase = PH_ESC;
            end else begin
               bc                 = (bc == COUNT_MAX) ? bc : bc + 1'b1;
               res_byte[k[0]]     = char_in;
               res_length[k[0]]   = bc;
               res_consumed[k[0]] = cc;
               k                  = k + 2'd1;
            end
         end
      end

      // every final result returns to idle with cleared counts
      if (done) begin
         st = ESC_STATE_IDLE;
         bc = '0;
         cc = '0;
      end

      nxt_state      = st;
      nxt_byte_count = bc;
      nxt_char_count = cc;
      n_results      = k;
   end

endmodule

FILE: hw/rtl/csu_rsp_fifo.sv
// Four-entry result queue; takes up to two results per cycle while it has room, gives one per cycle when out_ready.
// No package dependency; includes assert_macros.svh.
`include "assert_macros.svh"

module csu_rsp_fifo #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   push_n,
   input  logic [W-1:0] push_data0,
   input  logic [W-1:0] push_data1,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = AW + 1;

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] head_ff;
   logic [AW-1:0] tail_ff;
   logic [CW-1:0] count_ff;
   logic          pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[head_ff];
   assign pop       = out_valid && out_ready;
   // room for the worst case of two results from one character
   assign room      = (count_ff <= CW'(DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (pop) begin
            head_ff <= head_ff + 1'b1;
         end
         tail_ff  <= tail_ff + AW'(push_n);
         count_ff <= count_ff + CW'(push_n) - CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[tail_ff] <= push_data0;
      end
      if (push_n == 2'd2) begin
         mem_ff[tail_ff + 1'b1] <= push_data1;
      end
   end

   `ASSERT_PROP(a_push_has_room, clock, reset, push_n != 2'd0 |-> count_ff <= CW'(DEPTH - 2))
   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CW'(DEPTH))
   `ASSERT_PROP(a_pop_only_advance, clock, reset, pop && push_n == 2'd0 |=> count_ff == $past(count_ff) - 1'b1)

endmodule

FILE: hw/rtl/c_string_unescaper.sv
// Top level of the streaming C string unescaper: input register, decode, result queue.
// Depends on csu_pkg, csu_step, csu_rsp_fifo and assert_macros.svh.
//
//   port group | direction | carries
//   req_*      | in        | one string character per transfer
//   rsp_*      | out       | decoded byte or final status, with counts
//   csr_*      | in        | quote_mode write, no handshake
//
// One character per cycle while the queue has room: a character is registered
// on transfer, decoded from the input register, and its results land in a
// four-entry queue. A character that ends an octal run and also gives a byte
// or status yields two results; the output gives one per cycle when rsp_ready.
// Reset is synchronous, active high, and returns the decoder to idle.
// A stalled result side fills the queue, then holds the input register.
`include "assert_macros.svh"

module c_string_unescaper
   import csu_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic [2:0]             rsp_kind,
   output logic [COUNT_WIDTH-1:0] rsp_out_length,
   output logic [COUNT_WIDTH-1:0] rsp_consumed,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic                   csr_wdata
);

   localparam int RW = 8 + 3 + 2 * COUNT_WIDTH + 1;

   logic                   quote_mode_ff;
   logic                   in_valid_ff;
   logic [7:0]             char_ff;
   esc_state_type          esc_ff;
   logic [COUNT_WIDTH-1:0] byte_count_ff;
   logic [COUNT_WIDTH-1:0] char_count_ff;

   esc_state_type          esc_in;
   logic [COUNT_WIDTH-1:0] byte_count_in;
   logic [COUNT_WIDTH-1:0] char_count_in;
   logic [1:0]             n_results;
   logic                   step_done;
   logic [7:0]             res_byte [2];
   logic [2:0]             res_kind [2];
   logic [COUNT_WIDTH-1:0] res_length [2];
   logic [COUNT_WIDTH-1:0] res_consumed [2];

   logic                   fifo_room;
   logic                   step_fire;
   logic [1:0]             push_n;
   logic [RW-1:0]          push_data0;
   logic [RW-1:0]          push_data1;
   logic [RW-1:0]          out_data;

   assign step_fire = in_valid_ff && fifo_room;
   assign req_ready = !in_valid_ff || step_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_mode_ff <= 1'b0;
         in_valid_ff   <= 1'b0;
         esc_ff        <= ESC_STATE_IDLE;
         byte_count_ff <= '0;
         char_count_ff <= '0;
      end else begin
         if (csr_we) begin
            quote_mode_ff <= csr_wdata;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step_fire) begin
            esc_ff        <= esc_in;
            byte_count_ff <= byte_count_in;
            char_count_ff <= char_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_in;
      end
   end

   csu_step #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_step (
      .quote_mode     (quote_mode_ff),
      .char_in        (char_ff),
      .cur_state      (esc_ff),
      .cur_byte_count (byte_count_ff),
      .cur_char_count (char_count_ff),
      .nxt_state      (esc_in),
      .nxt_byte_count (byte_count_in),
      .nxt_char_count (char_count_in),
      .n_results      (n_results),
      .done           (step_done),
      .res_byte       (res_byte),
      .res_kind       (res_kind),
      .res_length     (res_length),
      .res_consumed   (res_consumed)
   );

   // the later of the two results is always the last one for this character
   assign push_n     = step_fire ? n_results : 2'd0;
   assign push_data0 = {res_byte[0], res_kind[0], res_length[0], res_consumed[0],
                        n_results == 2'd1};
   assign push_data1 = {res_byte[1], res_kind[1], res_length[1], res_consumed[1], 1'b1};

   csu_rsp_fifo #(
      .W(RW)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .room       (fifo_room),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign {rsp_out_byte, rsp_kind, rsp_out_length, rsp_consumed, rsp_last} = out_data;

   `ASSERT_PROP(a_final_clears, clock, reset, step_fire && step_done |=> esc_ff.phase == PH_IDLE && byte_count_ff == '0 && char_count_ff == '0)
   `ASSERT_PROP(a_held_char, clock, reset, in_valid_ff && !step_fire |=> in_valid_ff && $stable(char_ff))
   `ASSERT_PROP(a_done_emits, clock, reset, step_done |-> n_results != 2'd0)

endmodule
